### src/pwld_pkg.sv
// Shared types and constants for the step-line LED dimmer controller.
// No dependencies; imported by pwld_engine and the core top level.
package pwld_pkg;

   // Fixed widths of fields and counters.
   localparam int LVL_W   = 8;   // holds any level up to 255
   localparam int CNT_W   = 20;  // phase counter, wide enough for settle time
   localparam int PULSE_W = 16;  // pulse and gap register width
   localparam int OUT_LVL_W = 6; // reported level width

   // Request command codes.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_POWER = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_SHORT_LOW = 2'd0;
   localparam logic [1:0] REG_LONG_LOW  = 2'd1;
   localparam logic [1:0] REG_GAP       = 2'd2;
   localparam logic [1:0] REG_SETTLE    = 2'd3;

   // Configuration reset values.
   localparam logic [PULSE_W-1:0] RST_SHORT_LOW = 16'd200;
   localparam logic [PULSE_W-1:0] RST_LONG_LOW  = 16'd4000;
   localparam logic [PULSE_W-1:0] RST_GAP       = 16'd200;
   localparam logic [CNT_W-1:0]   RST_SETTLE    = 20'd20000;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_LOW    = 2'd2,
      PH_GAP    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [PULSE_W-1:0] short_low_ticks;
      logic [PULSE_W-1:0] long_low_ticks;
      logic [PULSE_W-1:0] gap_ticks;
      logic [CNT_W-1:0]   settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic             supply_enabled;
      logic             led_enabled;
      logic             led_after_walk;
      logic             line_level;
      phase_type        phase;
      logic [CNT_W-1:0] phase_count;
      logic [LVL_W-1:0] tracked_level;
      logic [LVL_W-1:0] target_level;
      logic             going_up;
   } st_type;

   typedef struct packed {
      logic                 step_line;
      logic                 power_on;
      logic                 led_on;
      logic [OUT_LVL_W-1:0] current_level;
      logic                 busy_res;
   } res_type;

endpackage

### src/pulse_width_led_dimmer_stepper_core.sv
// Top level of the step-line LED dimmer controller; depends on pwld_pkg, pwld_engine.
// A request waits in the input register; the single-pass state update loads its result
//   into the result register once the result slot is free or draining.
// One request per cycle; req_ready is low only with both stages full and rsp_ready low.
// Reset (synchronous): supply and LED off, line high, idle, levels at LEVELS,
//   timing registers back to their defaults.
module pulse_width_led_dimmer_stepper_core #(
   parameter int LEVELS      = 32,
   parameter int START_LEVEL = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [pwld_pkg::LVL_W-1:0]    req_level,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_step_line,
   output logic                          rsp_power_on,
   output logic                          rsp_led_on,
   output logic [pwld_pkg::OUT_LVL_W-1:0] rsp_current_level,
   output logic                          rsp_busy_res,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [pwld_pkg::CNT_W-1:0]    csr_wdata
);
   import pwld_pkg::*;

   // ---- configuration registers ----
   // Writes are always taken; wide data is cut to each register's width.
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SHORT_LOW: cfg_in.short_low_ticks = csr_wdata[PULSE_W-1:0];
            REG_LONG_LOW:  cfg_in.long_low_ticks  = csr_wdata[PULSE_W-1:0];
            REG_GAP:       cfg_in.gap_ticks       = csr_wdata[PULSE_W-1:0];
            REG_SETTLE:    cfg_in.settle_ticks    = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_low_ticks <= RST_SHORT_LOW;
         cfg_ff.long_low_ticks  <= RST_LONG_LOW;
         cfg_ff.gap_ticks       <= RST_GAP;
         cfg_ff.settle_ticks    <= RST_SETTLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- input register ----
   logic             in_valid_ff, in_valid_in;
   logic [1:0]       in_cmd_ff;
   logic [LVL_W-1:0] in_level_ff;
   logic             req_take;
   logic             fire;       // request in input register is processed now

   // The request is processed whenever the result slot is free or draining,
   // so a waiting result never stalls the next request by more than its own hold.
   assign fire      = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_cmd;
         in_level_ff <= req_level;
      end
   end

   // ---- dimmer state and step logic ----
   res_type res_next;

   pwld_engine #(
      .LEVELS      (LEVELS),
      .START_LEVEL (START_LEVEL)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .fire  (fire),
      .cmd   (in_cmd_ff),
      .level (in_level_ff),
      .res   (res_next)
   );

   // ---- result register ----
   logic    rsp_valid_ff, rsp_valid_in;
   res_type res_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_line     = res_ff.step_line;
   assign rsp_power_on      = res_ff.power_on;
   assign rsp_led_on        = res_ff.led_on;
   assign rsp_current_level = res_ff.current_level;
   assign rsp_busy_res      = res_ff.busy_res;

endmodule

### src/pwld_engine.sv
// Dimmer state and per-request next-state logic for the step-line controller.
// Depends on pwld_pkg; instantiated by pulse_width_led_dimmer_stepper_core.
module pwld_engine #(
   parameter int LEVELS      = 32,
   parameter int START_LEVEL = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pwld_pkg::cfg_type     cfg,
   input  logic                  fire,
   input  logic [1:0]            cmd,
   input  logic [pwld_pkg::LVL_W-1:0] level,
   output pwld_pkg::res_type     res
);
   import pwld_pkg::*;

   localparam logic [LVL_W-1:0] MAX_LVL   = LVL_W'(LEVELS);
   localparam logic [LVL_W-1:0] START_LVL = LVL_W'(START_LEVEL);

   st_type st_ff, st_in;

   // idle: start the next pulse toward target, or finish the walk
   function automatic st_type idle_tick(st_type s, cfg_type c);
      st_type r;
      r = s;
      if (s.tracked_level < s.target_level) begin
         r.going_up    = 1'b1;
         r.line_level  = 1'b0;
         r.phase       = PH_LOW;
         r.phase_count = (c.short_low_ticks == '0) ? CNT_W'(1)
                                                    : CNT_W'(c.short_low_ticks);
      end else if (s.tracked_level > s.target_level) begin
         r.going_up    = 1'b0;
         r.line_level  = 1'b0;
         r.phase       = PH_LOW;
         r.phase_count = (c.long_low_ticks == '0) ? CNT_W'(1)
                                                   : CNT_W'(c.long_low_ticks);
      end else if (s.led_after_walk) begin
         r.led_enabled    = 1'b1;
         r.led_after_walk = 1'b0;
      end
      return r;
   endfunction

   // next state
   always_comb begin
      st_in = st_ff;
      if (fire) begin
         unique case (cmd)
            CMD_TICK: begin
               unique case (st_ff.phase)
                  PH_SETTLE: begin
                     if (st_ff.phase_count > CNT_W'(1)) begin
                        st_in.phase_count = st_ff.phase_count - CNT_W'(1);
                     end else begin
                        st_in.phase_count   = '0;
                        st_in.tracked_level = START_LVL;
                        st_in.phase         = PH_IDLE;
                        st_in               = idle_tick(st_in, cfg);
                     end
                  end
                  PH_LOW: begin
                     if (st_ff.phase_count > CNT_W'(1)) begin
                        st_in.phase_count = st_ff.phase_count - CNT_W'(1);
                     end else begin
                        st_in.line_level    = 1'b1;
                        st_in.tracked_level = st_ff.going_up
                                              ? st_ff.tracked_level + LVL_W'(1)
                                              : st_ff.tracked_level - LVL_W'(1);
                        st_in.phase         = PH_GAP;
                        st_in.phase_count   = (cfg.gap_ticks == '0) ? CNT_W'(1)
                                              : CNT_W'(cfg.gap_ticks);
                     end
                  end
                  PH_GAP: begin
                     if (st_ff.phase_count > CNT_W'(1)) begin
                        st_in.phase_count = st_ff.phase_count - CNT_W'(1);
                     end else begin
                        st_in.phase_count = '0;
                        st_in.phase       = PH_IDLE;
                        st_in             = idle_tick(st_in, cfg);
                     end
                  end
                  PH_IDLE: begin
                     st_in = idle_tick(st_ff, cfg);
                  end
               endcase
            end
            CMD_SET: begin
               if (level == '0) begin
                  st_in.led_enabled    = 1'b0;
                  st_in.led_after_walk = 1'b0;
               end else begin
                  st_in.led_enabled  = 1'b1;
                  st_in.target_level = (level > MAX_LVL) ? MAX_LVL : level;
               end
            end
            CMD_POWER: begin
               st_in.supply_enabled = 1'b1;
               st_in.line_level     = 1'b1;
               st_in.target_level   = MAX_LVL;
               st_in.led_after_walk = 1'b1;
               st_in.phase          = PH_SETTLE;
               st_in.phase_count    = cfg.settle_ticks;
            end
            default: ;  // unused code, state unchanged
         endcase
      end
   end

   // result for this request, taken from the updated state
   always_comb begin
      res.step_line     = st_in.line_level;
      res.power_on      = st_in.supply_enabled;
      res.led_on        = st_in.led_enabled;
      res.current_level = st_in.tracked_level[OUT_LVL_W-1:0];
      res.busy_res      = (st_in.phase != PH_IDLE) ||
                          (st_in.tracked_level != st_in.target_level) ||
                          st_in.led_after_walk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.supply_enabled <= 1'b0;
         st_ff.led_enabled    <= 1'b0;
         st_ff.led_after_walk <= 1'b0;
         st_ff.line_level     <= 1'b1;
         st_ff.phase          <= PH_IDLE;
         st_ff.phase_count    <= '0;
         st_ff.tracked_level  <= MAX_LVL;
         st_ff.target_level   <= MAX_LVL;
         st_ff.going_up       <= 1'b0;
      end else begin
         st_ff <= st_in;
      end
   end

   // line only goes low inside a pulse
   a_line_low_in_pulse: assert property (@(posedge clock) disable iff (reset)
      !st_ff.line_level |-> st_ff.phase == PH_LOW)
      else $error("step line low outside pulse phase");

   // timed phases never hold an exhausted count
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_LOW || st_ff.phase == PH_GAP) |-> st_ff.phase_count != '0)
      else $error("pulse or gap phase with zero count");

   // LED arm only follows a power-up
   a_arm_needs_supply: assert property (@(posedge clock) disable iff (reset)
      st_ff.led_after_walk |-> st_ff.supply_enabled)
      else $error("LED armed without supply");

   // walking never steps below level one
   a_tracked_nonzero: assert property (@(posedge clock) disable iff (reset)
      st_ff.tracked_level != '0)
      else $error("tracked level reached zero");

endmodule

### tb/tb_pulse_width_led_dimmer_stepper_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the step-line LED dimmer controller core: directed and random
// requests go in, and every result is checked against a cycle-free model of the dimmer state.
// Depends on pwld_pkg and pulse_width_led_dimmer_stepper_core.
module tb_pulse_width_led_dimmer_stepper_core;
   import pwld_pkg::*;

   localparam int LEVELS      = 32;
   localparam int START_LEVEL = 16;

   // The command field is two bits wide; code 3 has no function and must leave state alone.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT  = 600000; // generous bound on the whole run
   localparam int DRAIN_CYCLES = 4;      // two register stages, plus margin
   localparam int MAX_REPORTS  = 30;     // keep the log short if the core is badly broken

   // ------------------------------------------------------------------
   // Clock, reset and the ports of the core
   // ------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_cmd   = CMD_TICK;
   logic [LVL_W-1:0]     req_level = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_step_line;
   logic                 rsp_power_on;
   logic                 rsp_led_on;
   logic [OUT_LVL_W-1:0] rsp_current_level;
   logic                 rsp_busy_res;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = REG_SHORT_LOW;
   logic [CNT_W-1:0]     csr_wdata = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pulse_width_led_dimmer_stepper_core #(
      .LEVELS      (LEVELS),
      .START_LEVEL (START_LEVEL)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_step_line     (rsp_step_line),
      .rsp_power_on      (rsp_power_on),
      .rsp_led_on        (rsp_led_on),
      .rsp_current_level (rsp_current_level),
      .rsp_busy_res      (rsp_busy_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Dimmer model: timing registers, controller state, expected results
   // ------------------------------------------------------------------
   cfg_type timing;
   st_type  dimmer;
   res_type pending_results[$];   // expected results, oldest first

   int mismatch_count = 0;
   int cycle_count    = 0;
   int requests_sent  = 0;

   // Idling controls, changed by the tests between phases.
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int hold_off_len  = 0;    // nonzero asks the receiver for one long hold-off

   // A zero width or settle time behaves like one tick.
   function automatic logic [CNT_W-1:0] at_least_one_tick(input logic [CNT_W-1:0] ticks);
      return (ticks == '0) ? CNT_W'(1) : ticks;
   endfunction

   // Idle tick: launch the next step pulse toward the target, or, once the walk is done,
   // turn on the LED that a power-up armed.
   task automatic dimmer_idle_step();
      if (dimmer.tracked_level < dimmer.target_level) begin
         dimmer.going_up    = 1'b1;
         dimmer.line_level  = 1'b0;
         dimmer.phase       = PH_LOW;
         dimmer.phase_count = at_least_one_tick(CNT_W'(timing.short_low_ticks));
      end else if (dimmer.tracked_level > dimmer.target_level) begin
         dimmer.going_up    = 1'b0;
         dimmer.line_level  = 1'b0;
         dimmer.phase       = PH_LOW;
         dimmer.phase_count = at_least_one_tick(CNT_W'(timing.long_low_ticks));
      end else if (dimmer.led_after_walk) begin
         dimmer.led_enabled    = 1'b1;
         dimmer.led_after_walk = 1'b0;
      end
   endtask

   task automatic dimmer_tick();
      case (dimmer.phase)
         PH_SETTLE: begin
            if (dimmer.phase_count > 1) begin
               dimmer.phase_count--;
            end else begin
               // settling over: the dimmer now sits at its power-on level
               dimmer.phase_count   = '0;
               dimmer.tracked_level = LVL_W'(START_LEVEL);
               dimmer.phase         = PH_IDLE;
               dimmer_idle_step();
            end
         end
         PH_LOW: begin
            if (dimmer.phase_count > 1) begin
               dimmer.phase_count--;
            end else begin
               // end of the low pulse: the dimmer takes the step here
               dimmer.line_level = 1'b1;
               if (dimmer.going_up) dimmer.tracked_level++;
               else dimmer.tracked_level--;
               dimmer.phase       = PH_GAP;
               dimmer.phase_count = at_least_one_tick(CNT_W'(timing.gap_ticks));
            end
         end
         PH_GAP: begin
            if (dimmer.phase_count > 1) begin
               dimmer.phase_count--;
            end else begin
               dimmer.phase_count = '0;
               dimmer.phase       = PH_IDLE;
               dimmer_idle_step();
            end
         end
         default: dimmer_idle_step();
      endcase
   endtask

   // Applies one accepted request to the model and returns the result it must produce.
   task automatic advance_dimmer(input logic [1:0] cmd, input logic [LVL_W-1:0] level,
                                 output res_type res);
      logic [LVL_W-1:0] wanted;
      wanted = level;
      case (cmd)
         CMD_TICK: dimmer_tick();
         CMD_SET: begin
            if (wanted == '0) begin
               // level zero only switches the LED off; levels stay where they are
               dimmer.led_enabled    = 1'b0;
               dimmer.led_after_walk = 1'b0;
            end else begin
               if (wanted > LVL_W'(LEVELS)) wanted = LVL_W'(LEVELS);
               dimmer.led_enabled  = 1'b1;
               dimmer.target_level = wanted;
            end
         end
         CMD_POWER: begin
            // any pulse in flight is dropped; walk to full once settled
            dimmer.supply_enabled = 1'b1;
            dimmer.line_level     = 1'b1;
            dimmer.target_level   = LVL_W'(LEVELS);
            dimmer.led_after_walk = 1'b1;
            dimmer.phase          = PH_SETTLE;
            dimmer.phase_count    = timing.settle_ticks;
         end
         default: ; // unused code: state unchanged, just report it
      endcase
      res.step_line     = dimmer.line_level;
      res.power_on      = dimmer.supply_enabled;
      res.led_on        = dimmer.led_enabled;
      res.current_level = dimmer.tracked_level[OUT_LVL_W-1:0];
      res.busy_res      = (dimmer.phase != PH_IDLE) ||
                          (dimmer.tracked_level != dimmer.target_level) ||
                          dimmer.led_after_walk;
   endtask

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------
   // Mostly back to back, often a short idle, now and then a long pause.
   function automatic int pick_idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Levels: off now and then, mostly in range, the rest anywhere in the 8-bit field.
   function automatic logic [LVL_W-1:0] random_level();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return '0;
      if (roll < 75) return LVL_W'($urandom_range(1, LEVELS));
      return LVL_W'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offers one request and holds it until accepted. Valid is left high afterwards unless a
   // gap follows, so back-to-back requests never drop valid in between.
   task automatic send_request(input logic [1:0] cmd, input logic [LVL_W-1:0] level);
      res_type expected;
      int      gap;
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_level <= level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_dimmer(cmd, level, expected);
      pending_results.push_back(expected);
      requests_sent++;
      gap = req_gaps_on ? pick_idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every expected result is back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four timing registers; only called with the core drained.
   task automatic set_timing(input logic [PULSE_W-1:0] short_low,
                             input logic [PULSE_W-1:0] long_low,
                             input logic [PULSE_W-1:0] gap, input logic [CNT_W-1:0] settle);
      logic [1:0]       reg_ids [4];
      logic [CNT_W-1:0] values  [4];
      reg_ids = '{REG_SHORT_LOW, REG_LONG_LOW, REG_GAP, REG_SETTLE};
      values  = '{CNT_W'(short_low), CNT_W'(long_low), CNT_W'(gap), settle};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_ids[i];
         csr_wdata <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (reg_ids[i])
            REG_SHORT_LOW: timing.short_low_ticks = values[i][PULSE_W-1:0];
            REG_LONG_LOW:  timing.long_low_ticks  = values[i][PULSE_W-1:0];
            REG_GAP:       timing.gap_ticks       = values[i][PULSE_W-1:0];
            default:       timing.settle_ticks    = values[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side: random ready, optional long hold-off, and the checker
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         if (mismatch_count < MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      res_type expected;
      if (pending_results.size() == 0) begin
         if (mismatch_count < MAX_REPORTS)
            $error("result arrived with no request outstanding");
         mismatch_count++;
      end else begin
         expected = pending_results.pop_front();
         check_field("step_line",     8'(expected.step_line),     8'(rsp_step_line));
         check_field("power_on",      8'(expected.power_on),      8'(rsp_power_on));
         check_field("led_on",        8'(expected.led_on),        8'(rsp_led_on));
         check_field("current_level", 8'(expected.current_level), 8'(rsp_current_level));
         check_field("busy_res",      8'(expected.busy_res),      8'(rsp_busy_res));
      end
   endtask

   int stall_left = 0;
   int hold_left  = 0;

   // Values read right after the edge are the ones the core saw at that edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (hold_off_len != 0) begin
            hold_left    = hold_off_len;
            hold_off_len = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 3) == 0)
               stall_left = pick_idle_length();
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Default timing right after reset: tracked and target both at full, so nothing walks.
   // Covers the unused code, level zero before power-up and clamping of the widest level.
   task automatic test_idle_after_reset();
      send_request(CMD_TICK, 8'd0);
      send_request(CMD_UNUSED, 8'hFF);
      send_request(CMD_SET, 8'd0);
      send_request(CMD_SET, 8'd255);
      send_request(CMD_TICK, 8'hAA);
      send_request(CMD_SET, LVL_W'(LEVELS));
   endtask

   // All widths and the settle time at zero (each acts as one tick), which keeps walks short
   // enough to hit the special cases by hand.
   task automatic test_walk_corner_cases();
      wait_until_drained();
      set_timing('0, '0, '0, '0);
      // a walk runs before power-up since pulses are not gated by the supply
      send_request(CMD_SET, 8'd30);
      send_request(CMD_TICK, 8'd0);
      send_request(CMD_TICK, 8'd0);
      // power-up with a pulse just finished, then a new target while settling
      send_request(CMD_POWER, 8'd0);
      send_request(CMD_SET, 8'd20);
      send_request(CMD_TICK, 8'd0);   // settle ends at START_LEVEL, upward pulse starts
      send_request(CMD_TICK, 8'd0);
      // new target mid-walk: the gap under way still completes
      send_request(CMD_SET, 8'd1);
      send_request(CMD_TICK, 8'd0);
      send_request(CMD_TICK, 8'd0);
      send_request(CMD_SET, LVL_W'(LEVELS + 1));   // just above the top level
      send_request(CMD_TICK, 8'd0);
      send_request(CMD_SET, 8'd0);                 // LED off mid-walk, walk continues
      send_request(CMD_TICK, 8'd0);
      send_request(CMD_UNUSED, 8'd0);
   endtask

   // Widest pulse, gap and settle values: checks that the long counts hold the line and
   // that power-up abandons a pulse in flight.
   task automatic test_register_extremes();
      wait_until_drained();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd1);
      send_request(CMD_POWER, random_level());
      repeat (24) send_request(CMD_TICK, random_level());
      send_request(CMD_SET, 8'd200);
      send_request(CMD_POWER, random_level());
      send_request(CMD_TICK, random_level());
      wait_until_drained();
      set_timing(16'd1, 16'd1, 16'd1, 20'hFFFFF);
      send_request(CMD_POWER, random_level());
      repeat (12) send_request(CMD_TICK, random_level());
      send_request(CMD_SET, 8'd3);
      repeat (6) send_request(CMD_TICK, random_level());
   endtask

   // The receiver holds ready low for a long stretch while requests keep coming, so the
   // core fills both stages and has to drop req_ready.
   task automatic test_result_backpressure();
      wait_until_drained();
      set_timing(16'd2, 16'd3, 16'd1, 20'd2);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_off_len  = 300;
      send_request(CMD_POWER, random_level());
      repeat (60) send_request(($urandom_range(0, 4) == 0) ? CMD_SET : CMD_TICK, random_level());
   endtask

   // One random scene: power-up or a new level, then a run of ticks with some noise mixed in.
   task automatic run_scene();
      int ticks;
      int roll;
      if ($urandom_range(0, 99) < 20) send_request(CMD_POWER, LVL_W'($urandom_range(0, 255)));
      else send_request(CMD_SET, random_level());
      ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(5, 60);
      repeat (ticks) begin
         roll = $urandom_range(0, 99);
         if (roll < 90) send_request(CMD_TICK, LVL_W'($urandom_range(0, 255)));
         else if (roll < 95) send_request(CMD_SET, random_level());
         else if (roll < 98) send_request(CMD_UNUSED, LVL_W'($urandom_range(0, 255)));
         else send_request(CMD_POWER, LVL_W'($urandom_range(0, 255)));
      end
   endtask

   // Several phases, each with its own short timing and idling mix; the first uses the
   // smallest nonzero widths.
   task automatic test_random_traffic();
      int stop_at;
      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         wait_until_drained();
         if (phase_no == 0)
            set_timing(16'd1, 16'd1, 16'd1, 20'd1);
         else
            set_timing(PULSE_W'($urandom_range(0, 4)), PULSE_W'($urandom_range(0, 6)),
                       PULSE_W'($urandom_range(0, 3)), CNT_W'($urandom_range(0, 8)));
         req_gaps_on   = ($urandom_range(0, 2) != 0);
         rsp_stalls_on = ($urandom_range(0, 2) != 0);
         stop_at = requests_sent + 120;
         while (requests_sent < stop_at) run_scene();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      // model state matches the core's reset
      timing.short_low_ticks = RST_SHORT_LOW;
      timing.long_low_ticks  = RST_LONG_LOW;
      timing.gap_ticks       = RST_GAP;
      timing.settle_ticks    = RST_SETTLE;
      dimmer                 = '0;
      dimmer.line_level      = 1'b1;
      dimmer.phase           = PH_IDLE;
      dimmer.tracked_level   = LVL_W'(LEVELS);
      dimmer.target_level    = LVL_W'(LEVELS);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_walk_corner_cases();
      test_register_extremes();
      test_result_backpressure();
      test_random_traffic();
      wait_until_drained();

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
